// ----- rtl/core/smpq_pkg.sv -----
// shared constants for the sorted max priority queue
// sizes, operation codes and status codes; no dependencies
package smpq_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int OCNT_W = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

endpackage

// ----- rtl/core/smpq_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module smpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/sorted_max_priority_queue.sv -----
// Sorted maximum priority queue: keys are held in descending order in one key
// memory (one write port, one registered read port) walked by a sequencer, one
// entry per cycle. An insert walks from the tail towards the head, moving each
// smaller entry one place towards the tail, and writes the key behind the first
// entry not smaller than it, or at the head; a remove searches from the head
// and moves the later entries one place forward; a dump streams one result per
// cycle. Full, empty and an insert into an empty queue answer the cycle after
// start. busy is high while an operation walks the memory; the receiver cannot
// hold results off, and each is shown for exactly one cycle on result_valid.
// depends on smpq_pkg and smpq_ram
module sorted_max_priority_queue
    import smpq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic signed [KEY_W-1:0]  key_value,
    output logic                     result_valid,
    output logic signed [KEY_W-1:0]  out_key,
    output logic [POS_W-1:0]         out_position,
    output logic [1:0]               status,
    output logic                     last_result,
    output logic [OCNT_W-1:0]        entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS0,
        S_FIND,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    logic                    res_v_reg, res_v_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic [1:0]              res_stat_reg, res_stat_next;
    logic                    res_last_reg, res_last_next;
    logic [OCNT_W-1:0]       res_cnt_reg, res_cnt_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]        cur_ext;
    logic [CNT_W-1:0]        count_m1;
    logic [CNT_W-1:0]        count_p1;
    logic                    at_last;
    logic                    rd_less;
    logic                    rd_equal;

    smpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_ext  = CNT_W'(cur_reg);
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_p1 = count_reg + CNT_W'(1);
    assign at_last  = (cur_ext == count_m1);
    assign rd_less  = ($signed(ram_rdata) < key_reg);
    assign rd_equal = (ram_rdata == key_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        res_v_next    = 1'b0;
        res_key_next  = res_key_reg;
        res_pos_next  = res_pos_reg;
        res_stat_next = res_stat_reg;
        res_last_next = res_last_reg;
        res_cnt_next  = res_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = key_reg;
        ram_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = key_value;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_v_next    = 1'b1;
                                res_key_next  = key_value;
                                res_pos_next  = '0;
                                res_stat_next = STAT_FULL;
                                res_last_next = 1'b1;
                                res_cnt_next  = OCNT_W'(count_reg);
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = '0;
                                ram_wdata     = key_value;
                                count_next    = CNT_W'(1);
                                res_v_next    = 1'b1;
                                res_key_next  = key_value;
                                res_pos_next  = '0;
                                res_stat_next = STAT_OK;
                                res_last_next = 1'b1;
                                res_cnt_next  = OCNT_W'(1);
                            end
                            else
                            begin
                                // walk from the tail towards the head
                                ram_raddr  = count_m1[IDX_W-1:0];
                                cur_next   = count_m1[IDX_W-1:0];
                                state_next = S_INS;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_v_next    = 1'b1;
                                res_key_next  = key_value;
                                res_pos_next  = '0;
                                res_stat_next = STAT_NOT_FOUND;
                                res_last_next = 1'b1;
                                res_cnt_next  = '0;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                cur_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_v_next    = 1'b1;
                                res_key_next  = '0;
                                res_pos_next  = '0;
                                res_stat_next = STAT_EMPTY;
                                res_last_next = 1'b1;
                                res_cnt_next  = '0;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                cur_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg + IDX_W'(1);
                if (rd_less)
                begin
                    // smaller entry moves one place towards the tail
                    ram_wdata = ram_rdata;
                    if (cur_reg == '0)
                    begin
                        state_next = S_INS0;
                    end
                    else
                    begin
                        ram_raddr = cur_reg - IDX_W'(1);
                        cur_next  = cur_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    ram_wdata     = key_reg;
                    count_next    = count_p1;
                    res_v_next    = 1'b1;
                    res_key_next  = key_reg;
                    res_pos_next  = POS_W'(cur_reg + IDX_W'(1));
                    res_stat_next = STAT_OK;
                    res_last_next = 1'b1;
                    res_cnt_next  = OCNT_W'(count_p1);
                    state_next    = S_IDLE;
                end
            end

            S_INS0:
            begin
                ram_we        = 1'b1;
                ram_waddr     = '0;
                ram_wdata     = key_reg;
                count_next    = count_p1;
                res_v_next    = 1'b1;
                res_key_next  = key_reg;
                res_pos_next  = '0;
                res_stat_next = STAT_OK;
                res_last_next = 1'b1;
                res_cnt_next  = OCNT_W'(count_p1);
                state_next    = S_IDLE;
            end

            S_FIND:
            begin
                // next entry is fetched ahead, needed both for search and shift
                if (!at_last)
                begin
                    ram_raddr = cur_reg + IDX_W'(1);
                end
                if (rd_equal)
                begin
                    pos_next = cur_reg;
                    if (at_last)
                    begin
                        count_next    = count_m1;
                        res_v_next    = 1'b1;
                        res_key_next  = key_reg;
                        res_pos_next  = POS_W'(cur_reg);
                        res_stat_next = STAT_OK;
                        res_last_next = 1'b1;
                        res_cnt_next  = OCNT_W'(count_m1);
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (at_last)
                begin
                    res_v_next    = 1'b1;
                    res_key_next  = key_reg;
                    res_pos_next  = '0;
                    res_stat_next = STAT_NOT_FOUND;
                    res_last_next = 1'b1;
                    res_cnt_next  = OCNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                // read data is the entry one place behind cur
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = ram_rdata;
                if ((cur_ext + CNT_W'(1)) == count_m1)
                begin
                    count_next    = count_m1;
                    res_v_next    = 1'b1;
                    res_key_next  = key_reg;
                    res_pos_next  = POS_W'(pos_reg);
                    res_stat_next = STAT_OK;
                    res_last_next = 1'b1;
                    res_cnt_next  = OCNT_W'(count_m1);
                    state_next    = S_IDLE;
                end
                else
                begin
                    ram_raddr = cur_reg + IDX_W'(2);
                    cur_next  = cur_reg + IDX_W'(1);
                end
            end

            S_DUMP:
            begin
                res_v_next    = 1'b1;
                res_key_next  = $signed(ram_rdata);
                res_pos_next  = POS_W'(cur_reg);
                res_stat_next = STAT_OK;
                res_last_next = at_last;
                res_cnt_next  = OCNT_W'(count_reg);
                if (at_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_raddr = cur_reg + IDX_W'(1);
                    cur_next  = cur_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        res_key_reg  <= res_key_next;
        res_pos_reg  <= res_pos_next;
        res_stat_reg <= res_stat_next;
        res_last_reg <= res_last_next;
        res_cnt_reg  <= res_cnt_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_v_reg;
    assign out_key      = res_key_reg;
    assign out_position = res_pos_reg;
    assign status       = res_stat_reg;
    assign last_result  = res_last_reg;
    assign entry_count  = res_cnt_reg;

endmodule

// ----- rtl/core/smpq_checker.sv -----
// port-level checks for the sorted max priority queue, bound to the top level
// depends on smpq_pkg and sorted_max_priority_queue
module smpq_checker
    import smpq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [1:0]               opcode,
    input logic signed [KEY_W-1:0]  key_value,
    input logic                     result_valid,
    input logic signed [KEY_W-1:0]  out_key,
    input logic [POS_W-1:0]         out_position,
    input logic [1:0]               status,
    input logic                     last_result,
    input logic [OCNT_W-1:0]        entry_count
);

    // a dump streams without gaps until its last transaction
    a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> result_valid)
        else $error("dump stream broke before last result");

    // a non-final result only comes from a dump still walking the memory
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> busy && status == STAT_OK)
        else $error("non-final result while idle or with bad status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STAT_FULL |-> entry_count == OCNT_W'(DEPTH))
        else $error("full reported with queue not full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> entry_count <= OCNT_W'(DEPTH))
        else $error("entry count above depth");

    // an unused opcode is taken and leaves the block idle
    a_nop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_NOP |=> !busy && !result_valid)
        else $error("unused opcode started work");

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (.*);

// ----- bench/sorted_max_priority_queue_test.sv -----
// self-checking bench for the sorted max priority queue: a queued command driver,
// a result monitor and a behavioural copy of the queue that predicts every result
// depends on smpq_pkg and sorted_max_priority_queue
module sorted_max_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int RANDOM_ITEMS = 355;
    localparam int CALM_TAIL    = 60;   // no idling once this few commands remain

    typedef struct {
        logic [1:0]               op;
        logic signed [KEY_W-1:0]  key;
    } command_t;

    typedef struct {
        logic signed [KEY_W-1:0]  key;
        logic [POS_W-1:0]         pos;
        logic [1:0]               stat;
        logic                     last;
        logic [OCNT_W-1:0]        count;
    } queue_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               opcode = OP_INSERT;
    logic signed [KEY_W-1:0]  key_value = '0;
    logic                     busy;
    logic                     result_valid;
    logic signed [KEY_W-1:0]  out_key;
    logic [POS_W-1:0]         out_position;
    logic [1:0]               status;
    logic                     last_result;
    logic [OCNT_W-1:0]        entry_count;

    command_t                 queued_commands[$];
    queue_result_t            awaited_results[$];
    logic signed [KEY_W-1:0]  held_keys[DEPTH];
    int                       held_count = 0;
    int                       total_commands = 0;
    int                       accepted_commands = 0;
    int                       mismatches = 0;
    int                       idle_left = 0;

    sorted_max_priority_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_value    (key_value),
        .result_valid (result_valid),
        .out_key      (out_key),
        .out_position (out_position),
        .status       (status),
        .last_result  (last_result),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic add_command(input logic [1:0] op, input logic signed [KEY_W-1:0] key);
        command_t cmd;
        cmd.op  = op;
        cmd.key = key;
        queued_commands.push_back(cmd);
        total_commands++;
    endtask

    // small pool for duplicates and remove hits, plus the extremes and full-range keys
    function automatic logic signed [KEY_W-1:0] rand_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return int'($urandom_range(0, 7)) - 3;
        if (roll < 65)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 0;
                3:       return -1;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic expect_result(input logic signed [KEY_W-1:0] key, input int pos,
                                 input logic [1:0] stat, input logic last);
        queue_result_t res;
        res.key   = key;
        res.pos   = pos[POS_W-1:0];
        res.stat  = stat;
        res.last  = last;
        res.count = held_count[OCNT_W-1:0];
        awaited_results.push_back(res);
    endtask

    // applies one accepted command to the held keys and records what must come out
    task automatic apply_queue_command(input logic [1:0] op, input logic signed [KEY_W-1:0] key);
        int pos;
        int i;
        pos = 0;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= DEPTH)
                    expect_result(key, 0, STAT_FULL, 1'b1);
                else
                begin
                    // new key goes after every key greater than or equal to it
                    while (pos < held_count && !(held_keys[pos] < key))
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = key;
                    held_count++;
                    expect_result(key, pos, STAT_OK, 1'b1);
                end
            end
            OP_REMOVE:
            begin
                while (pos < held_count && held_keys[pos] != key)
                    pos++;
                if (pos >= held_count)
                    expect_result(key, 0, STAT_NOT_FOUND, 1'b1);
                else
                begin
                    for (i = pos; i + 1 < held_count; i++)
                        held_keys[i] = held_keys[i+1];
                    held_count--;
                    expect_result(key, pos, STAT_OK, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (held_count == 0)
                    expect_result('0, 0, STAT_EMPTY, 1'b1);
                else
                    for (i = 0; i < held_count; i++)
                        expect_result(held_keys[i], i, STAT_OK, i + 1 == held_count);
            end
            default: ;
        endcase
    endtask

    // driver: holds start until busy is low, then idles in bursts or sends the next command
    always @(posedge clk or negedge rst_n)
    begin
        command_t next_cmd;
        if (!rst_n)
        begin
            start     <= 1'b0;
            opcode    <= OP_INSERT;
            key_value <= '0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_queue_command(opcode, key_value);
                accepted_commands++;
                if (queued_commands.size() > CALM_TAIL
                    && !(queued_commands.size() > 150 && queued_commands.size() < 200)
                    && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 6);
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (queued_commands.size() != 0)
                begin
                    next_cmd = queued_commands.pop_front();
                    opcode    <= next_cmd.op;
                    key_value <= next_cmd.key;
                    start     <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result must match the oldest awaited one
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && result_valid)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: out_key %0d out_position %0d status %0d",
                       out_key, out_position, status);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_key !== want.key)
                begin
                    $error("out_key: expected %0d, got %0d", want.key, out_key);
                    mismatches++;
                end
                if (out_position !== want.pos)
                begin
                    $error("out_position: expected %0d, got %0d", want.pos, out_position);
                    mismatches++;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    mismatches++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, last_result);
                    mismatches++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [1:0]   op;
        int           remaining;
        int           seg_len;
        int           j;
        int unsigned  roll;
        bit           fill_phase;

        // directed: empty queue, fill with extremes and duplicates, overflow, removals
        add_command(OP_DUMP, 32'sh1234_5678);
        add_command(OP_REMOVE, 5);
        add_command(OP_INSERT, 0);
        add_command(OP_INSERT, 32'sh7fff_ffff);
        add_command(OP_INSERT, 32'sh8000_0000);
        add_command(OP_INSERT, -1);
        add_command(OP_INSERT, 0);
        add_command(OP_INSERT, 32'sh7fff_ffff);
        add_command(OP_INSERT, 1);
        add_command(OP_INSERT, -2);
        for (j = 0; j < DEPTH - 8; j++)
            add_command(OP_INSERT, $urandom);
        add_command(OP_INSERT, 7);
        add_command(OP_DUMP, '0);
        add_command(OP_REMOVE, 32'sh7fff_ffff);
        add_command(OP_REMOVE, 32'sh8000_0000);
        add_command(OP_REMOVE, 0);
        add_command(OP_REMOVE, 32'sh1357_9bdf);
        add_command(OP_NOP, 32'shffff_ffff);
        add_command(OP_DUMP, 32'shffff_ffff);

        // random: alternate filling and draining stretches so full and empty both recur
        remaining  = RANDOM_ITEMS;
        fill_phase = 1'b1;
        while (remaining > 0)
        begin
            seg_len = $urandom_range(20, 50);
            for (j = 0; j < seg_len && remaining > 0; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 13)
                    op = OP_DUMP;
                else if (roll < 20)
                    op = OP_NOP;
                else if ((roll < 85) == fill_phase)
                    op = OP_INSERT;
                else
                    op = OP_REMOVE;
                if (op == OP_DUMP || op == OP_NOP)
                    add_command(op, $urandom);
                else
                    add_command(op, rand_key());
                remaining--;
            end
            fill_phase = !fill_phase;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_commands < total_commands)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        // keep watching after the last awaited result so that any unexpected result is still caught
        repeat (DEPTH + 24) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("** sorted_max_priority_queue: PASSED **");
        else
            $display("** sorted_max_priority_queue: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** sorted_max_priority_queue: FAILED **");
        $finish;
    end

endmodule
